### rtl/ndfic_pkg.sv
// ----------------------------------------------------------------------------
// ndfic_pkg
// Shared types and constants of the row-major index converter.
// ----------------------------------------------------------------------------
package ndfic_pkg;

    localparam int IF_AXES         = 4;
    localparam int FLAT_BITS       = 48;
    localparam int STRIDE_BITS     = 36;
    localparam int PORT_COORD_BITS = 12;
    localparam int AXIS_COUNT_BITS = 3;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CMD_BITS        = 1;

    localparam int DEF_MAX_AXES    = 4;
    localparam int DEF_EXTENT_BITS = 12;

    // flat_index, coord_axis0..3
    localparam int S_TDATA_BITS = FLAT_BITS + IF_AXES * PORT_COORD_BITS;
    // flat_result, coord_result0, coord_result1..3, out_of_range
    localparam int M_FIELD_BITS = 2 * FLAT_BITS + (IF_AXES - 1) * PORT_COORD_BITS + 1;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic [CMD_BITS-1:0] CMD_TO_COORD = 1'b0;
    localparam logic [CMD_BITS-1:0] CMD_TO_FLAT  = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_AXIS_COUNT = 3'd0,
        CFG_EXTENT0    = 3'd1,
        CFG_EXTENT1    = 3'd2,
        CFG_EXTENT2    = 3'd3,
        CFG_EXTENT3    = 3'd4
    } ndfic_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRV_INIT,
        ST_DRV_MUL,
        ST_DRV_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DOT_START,
        ST_DOT_WAIT,
        ST_DONE
    } ndfic_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ndfic_unit_stat_t;

endpackage

### rtl/ndfic_mul.sv
// ----------------------------------------------------------------------------
// ndfic_mul
// Shift-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ndfic_mul #(
    parameter int MCAND_BITS  = ndfic_pkg::STRIDE_BITS,
    parameter int MPLIER_BITS = ndfic_pkg::DEF_EXTENT_BITS,
    parameter int ACC_BITS    = ndfic_pkg::FLAT_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [MCAND_BITS-1:0]       mcand,
    input  logic [MPLIER_BITS-1:0]      mplier,
    input  logic [ACC_BITS-1:0]         acc_in,
    output logic [ACC_BITS-1:0]         acc_out,
    output ndfic_pkg::ndfic_unit_stat_t stat
);
    import ndfic_pkg::*;

    localparam int CNT_BITS = $clog2(MPLIER_BITS + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [ACC_BITS-1:0]    mcand_reg;
    logic [MPLIER_BITS-1:0] mplier_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic [ACC_BITS-1:0]    acc_next;

    assign acc_next = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MPLIER_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= ACC_BITS'(mcand);
            mplier_reg <= mplier;
            acc_reg    <= acc_in;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign acc_out   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/ndfic_div.sv
// ----------------------------------------------------------------------------
// ndfic_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ndfic_div #(
    parameter int DIVIDEND_BITS = ndfic_pkg::FLAT_BITS,
    parameter int DIVISOR_BITS  = ndfic_pkg::STRIDE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DIVIDEND_BITS-1:0]    dividend,
    input  logic [DIVISOR_BITS-1:0]     divisor,
    output logic [DIVIDEND_BITS-1:0]    quotient,
    output logic [DIVISOR_BITS-1:0]     remainder,
    output ndfic_pkg::ndfic_unit_stat_t stat
);
    import ndfic_pkg::*;

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DIVIDEND_BITS-1:0] q_reg;
    logic [DIVISOR_BITS-1:0]  r_reg;
    logic [DIVISOR_BITS-1:0]  d_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     ge;
    logic [DIVISOR_BITS-1:0]  r_next;
    logic [DIVIDEND_BITS-1:0] q_next;

    always_comb
    begin
        trial  = {r_reg, q_reg[DIVIDEND_BITS-1]};
        ge     = (trial >= {1'b0, d_reg});
        diff   = trial - {1'b0, d_reg};
        r_next = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        q_next = {q_reg[DIVIDEND_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIVIDEND_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/nd_flat_index_converter_top.sv
// ----------------------------------------------------------------------------
// nd_flat_index_converter_top
// Row-major index converter for arrays of up to four axes.
// ----------------------------------------------------------------------------
// cfg_* writes the axis count (index 0) and the axis extents (1..4). Each write
// that hits a register re-derives strides and the element total: an init step,
// then one multiply per axis in use; cfg_ready and s_axis_tready stay low
// until that finishes.
// s_axis carries one request per transfer: tuser selects the operation
// (0 flat to coordinates, 1 coordinates to flat), tdata the operands.
// Flat to coordinates runs one 48-bit division per axis in use, one quotient
// bit per cycle; coordinates to flat runs one shift-add multiply-accumulate
// per axis in use. After the last axis the sequencer moves to ST_DONE, which
// loads the result into the output register once it is free; the sequencer
// then returns to idle and takes the next request.
// m_axis returns results from an output register; a new request is taken
// while the previous result still waits, and a stalled receiver holds the
// next finished result in the sequencer until the register drains.
// Reset: axis count 1, extents 1, strides 1, element total 1, m_axis empty.
// ----------------------------------------------------------------------------
module nd_flat_index_converter_top #(
    parameter int MAX_AXES    = ndfic_pkg::DEF_MAX_AXES,
    parameter int EXTENT_BITS = ndfic_pkg::DEF_EXTENT_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ndfic_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [((EXTENT_BITS > ndfic_pkg::AXIS_COUNT_BITS) ?
                   EXTENT_BITS : ndfic_pkg::AXIS_COUNT_BITS)-1:0] cfg_data,
    // requests
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // flat_index[47:0], coord_axis0..coord_axis3 (12 bits each)
    input  logic [ndfic_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    // cmd
    input  logic [ndfic_pkg::CMD_BITS-1:0]         s_axis_tuser,
    // results
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // flat_result[47:0], coord_result0[47:0], coord_result1..3 (12 bits
    // each), out_of_range, zero padding
    output logic [ndfic_pkg::M_TDATA_BITS-1:0]     m_axis_tdata
);
    import ndfic_pkg::*;

    localparam int LANES     = (MAX_AXES < IF_AXES) ? MAX_AXES : IF_AXES;
    localparam int AXW       = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int WIDE_BITS = (EXTENT_BITS > PORT_COORD_BITS) ? EXTENT_BITS : PORT_COORD_BITS;

    // control and configuration state
    ndfic_state_t                 state_reg;
    ndfic_state_t                 state_next;
    logic [AXW-1:0]               ax_reg;
    logic [AXIS_COUNT_BITS-1:0]   axis_count_reg;
    logic [EXTENT_BITS-1:0]       extent_reg [LANES];
    logic [STRIDE_BITS-1:0]       stride_reg [LANES];
    logic [FLAT_BITS-1:0]         total_reg;
    logic                         m_tvalid_reg;

    // item payload
    logic [FLAT_BITS-1:0]         s_reg;
    logic [FLAT_BITS-1:0]         flat_reg;
    logic                         oor_reg;
    logic [EXTENT_BITS-1:0]       in_coord_reg [LANES];
    logic [FLAT_BITS-1:0]         res_c0_reg;
    logic [PORT_COORD_BITS-1:0]   res_cx_reg [1:IF_AXES-1];
    logic [M_TDATA_BITS-1:0]      m_tdata_reg;

    // combinational
    logic                         cfg_fire;
    logic                         cfg_hit;
    logic                         s_fire;
    logic                         out_free;
    logic [AXIS_COUNT_BITS-1:0]   used_w;
    logic [AXW-1:0]               last_ax;
    logic [EXTENT_BITS-1:0]       ext_cur;
    logic [STRIDE_BITS-1:0]       stride_cur;
    logic [STRIDE_BITS-1:0]       divisor_w;
    logic [EXTENT_BITS-1:0]       coord_in_w [LANES];
    logic [PORT_COORD_BITS-1:0]   out_cx_w [1:IF_AXES-1];

    logic                         mul_start;
    logic [STRIDE_BITS-1:0]       mul_mcand;
    logic [EXTENT_BITS-1:0]       mul_mplier;
    logic [FLAT_BITS-1:0]         mul_acc_in;
    logic [FLAT_BITS-1:0]         mul_prod;
    ndfic_unit_stat_t             mul_stat;

    logic                         div_start;
    logic [FLAT_BITS-1:0]         div_quot;
    logic [STRIDE_BITS-1:0]       div_rem;
    ndfic_unit_stat_t             div_stat;

    logic                         s_ready_w;
    logic                         cfg_ready_w;
    logic                         out_load;

    // ------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------
    ndfic_mul #(
        .MCAND_BITS  (STRIDE_BITS),
        .MPLIER_BITS (EXTENT_BITS),
        .ACC_BITS    (FLAT_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .acc_in  (mul_acc_in),
        .acc_out (mul_prod),
        .stat    (mul_stat)
    );

    ndfic_div #(
        .DIVIDEND_BITS (FLAT_BITS),
        .DIVISOR_BITS  (STRIDE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_reg),
        .divisor   (divisor_w),
        .quotient  (div_quot),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign cfg_fire = cfg_valid && cfg_ready_w;
    assign s_fire   = s_axis_tvalid && s_ready_w;
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign cfg_hit  = (cfg_index == CFG_AXIS_COUNT) ||
                      ((cfg_index != '0) && (cfg_index <= CFG_INDEX_BITS'(LANES)));

    always_comb
    begin
        if (axis_count_reg == '0)
            used_w = AXIS_COUNT_BITS'(1);
        else if (axis_count_reg > AXIS_COUNT_BITS'(LANES))
            used_w = AXIS_COUNT_BITS'(LANES);
        else
            used_w = axis_count_reg;
    end

    assign last_ax    = AXW'(used_w - AXIS_COUNT_BITS'(1));
    assign ext_cur    = (extent_reg[ax_reg] == '0) ? EXTENT_BITS'(1) : extent_reg[ax_reg];
    assign stride_cur = stride_reg[ax_reg];
    assign divisor_w  = (stride_cur == '0) ? STRIDE_BITS'(1) : stride_cur;

    // zero-extend or trim the 12-bit port coordinates to the extent width
    for (genvar g = 0; g < LANES; g++)
    begin : g_coord_in
        logic [WIDE_BITS-1:0] wide_w;
        assign wide_w        = WIDE_BITS'(s_axis_tdata[FLAT_BITS + g*PORT_COORD_BITS +:
                                                       PORT_COORD_BITS]);
        assign coord_in_w[g] = wide_w[EXTENT_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire && cfg_hit)
                    state_next = ST_DRV_INIT;
                else if (s_fire)
                    state_next = (s_axis_tuser == CMD_TO_FLAT) ? ST_DOT_START : ST_DIV_START;
            end
            ST_DRV_INIT:  state_next = ST_DRV_MUL;
            ST_DRV_MUL:   state_next = ST_DRV_WAIT;
            ST_DRV_WAIT:
            begin
                if (mul_stat.done)
                    state_next = (ax_reg == '0) ? ST_IDLE : ST_DRV_MUL;
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = (ax_reg == last_ax) ? ST_DONE : ST_DIV_START;
            end
            ST_DOT_START: state_next = ST_DOT_WAIT;
            ST_DOT_WAIT:
            begin
                if (mul_stat.done)
                    state_next = (ax_reg == last_ax) ? ST_DONE : ST_DOT_START;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_start   = 1'b0;
        mul_mcand   = stride_cur;
        mul_mplier  = in_coord_reg[ax_reg];
        mul_acc_in  = flat_reg;
        div_start   = 1'b0;
        s_ready_w   = 1'b0;
        cfg_ready_w = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready_w = 1'b1;
                // configuration wins a same-cycle collision
                s_ready_w   = !cfg_valid;
            end
            ST_DRV_MUL:
            begin
                mul_start  = 1'b1;
                mul_mcand  = total_reg[STRIDE_BITS-1:0];
                mul_mplier = ext_cur;
                mul_acc_in = '0;
            end
            ST_DIV_START: div_start = 1'b1;
            ST_DOT_START: mul_start = 1'b1;
            ST_DONE:      out_load  = out_free;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ax_reg         <= '0;
            axis_count_reg <= AXIS_COUNT_BITS'(1);
            total_reg      <= FLAT_BITS'(1);
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                extent_reg[i] <= EXTENT_BITS'(1);
                stride_reg[i] <= STRIDE_BITS'(1);
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                if (cfg_index == CFG_AXIS_COUNT)
                    axis_count_reg <= cfg_data[AXIS_COUNT_BITS-1:0];
                for (int i = 0; i < LANES; i++)
                begin
                    if (cfg_index == CFG_INDEX_BITS'(int'(CFG_EXTENT0) + i))
                        extent_reg[i] <= cfg_data[EXTENT_BITS-1:0];
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                        ax_reg <= '0;
                end
                ST_DRV_INIT:
                begin
                    total_reg <= FLAT_BITS'(1);
                    ax_reg    <= last_ax;
                    for (int i = 0; i < LANES; i++)
                        stride_reg[i] <= STRIDE_BITS'(1);
                end
                ST_DRV_MUL:
                begin
                    stride_reg[ax_reg] <= total_reg[STRIDE_BITS-1:0];
                end
                ST_DRV_WAIT:
                begin
                    if (mul_stat.done)
                    begin
                        total_reg <= mul_prod;
                        if (ax_reg != '0)
                            ax_reg <= ax_reg - 1'b1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_stat.done && ax_reg != last_ax)
                        ax_reg <= ax_reg + 1'b1;
                end
                ST_DOT_WAIT:
                begin
                    if (mul_stat.done && ax_reg != last_ax)
                        ax_reg <= ax_reg + 1'b1;
                end
                default: ;
            endcase

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Item datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s_reg      <= s_axis_tdata[FLAT_BITS-1:0];
            flat_reg   <= '0;
            oor_reg    <= (s_axis_tuser == CMD_TO_COORD) &&
                          (s_axis_tdata[FLAT_BITS-1:0] >= total_reg);
            res_c0_reg <= '0;
            for (int i = 1; i < IF_AXES; i++)
                res_cx_reg[i] <= '0;
            for (int i = 0; i < LANES; i++)
                in_coord_reg[i] <= coord_in_w[i];
        end
        else
        begin
            case (state_reg)
                ST_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        // carry the remainder on to the next axis
                        s_reg <= FLAT_BITS'(div_rem);
                        if (ax_reg == '0)
                            res_c0_reg <= div_quot;
                        for (int i = 1; i < IF_AXES; i++)
                        begin
                            if (i < LANES && ax_reg == AXW'(i))
                                res_cx_reg[i] <= div_quot[PORT_COORD_BITS-1:0];
                        end
                    end
                end
                ST_DOT_START:
                begin
                    if (in_coord_reg[ax_reg] >= ext_cur)
                        oor_reg <= 1'b1;
                end
                ST_DOT_WAIT:
                begin
                    if (mul_stat.done)
                        flat_reg <= mul_prod;
                end
                default: ;
            endcase
        end

        if (out_load)
            m_tdata_reg <= M_TDATA_BITS'({oor_reg, out_cx_w[3], out_cx_w[2], out_cx_w[1],
                                          res_c0_reg, flat_reg});
    end

    for (genvar g = 1; g < IF_AXES; g++)
    begin : g_out_cx
        if (g < LANES)
        begin : g_used
            assign out_cx_w[g] = res_cx_reg[g];
        end
        else
        begin : g_none
            assign out_cx_w[g] = '0;
        end
    end

    assign cfg_ready     = cfg_ready_w;
    assign s_axis_tready = s_ready_w;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("request transfer did not start a conversion");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy together");

    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("arithmetic unit still busy in idle");

    a_cfg_derives: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_hit) |=> (state_reg == ST_DRV_INIT))
        else $error("configuration write did not start stride derivation");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the row-major index converter. A shadow model of
// the axis shape (count, extents, strides, element total) predicts every
// conversion; results are checked in order against the predictions. Shapes
// are reprogrammed between phases while the converter is drained, and both
// stream sides are throttled at random until a final unthrottled regime.
// ----------------------------------------------------------------------------
module testbench;
    import ndfic_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 165;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [FLAT_BITS-1:0]      FLAT_MAX        = '1;
    localparam logic [PORT_COORD_BITS-1:0] COORD_MAX      = '1;

    typedef struct packed {
        logic [CMD_BITS-1:0]                           cmd;
        logic [FLAT_BITS-1:0]                          flat;
        logic [IF_AXES-1:0][PORT_COORD_BITS-1:0]       coord;
    } index_req_t;

    typedef struct packed {
        logic [FLAT_BITS-1:0]                          flat_result;
        logic [FLAT_BITS-1:0]                          coord0;
        logic [IF_AXES-1:1][PORT_COORD_BITS-1:0]       coord_tail;
        logic                                          out_of_range;
    } index_res_t;

    logic                              clk            = 1'b0;
    logic                              rst_n          = 1'b0;
    logic                              cfg_valid      = 1'b0;
    logic                              cfg_ready;
    logic [CFG_INDEX_BITS-1:0]         cfg_index      = '0;
    logic [DEF_EXTENT_BITS-1:0]        cfg_data       = '0;
    logic                              s_axis_tvalid  = 1'b0;
    logic                              s_axis_tready;
    logic [S_TDATA_BITS-1:0]           s_axis_tdata   = '0;
    logic [CMD_BITS-1:0]               s_axis_tuser   = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]           m_axis_tdata;

    // shadow copy of the converter's shape registers and derived values
    logic [AXIS_COUNT_BITS-1:0]        shape_count;
    logic [DEF_EXTENT_BITS-1:0]        shape_extent [IF_AXES];
    logic [STRIDE_BITS-1:0]            shape_stride [IF_AXES];
    logic [FLAT_BITS-1:0]              shape_total;

    index_req_t                        pending_req [$];
    index_res_t                        expected_res [$];
    index_req_t                        in_flight;
    int                                send_idle_pct;
    int                                recv_idle_pct;
    int                                error_count = 0;
    int                                cycle_count = 0;

    nd_flat_index_converter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int axes_in_use();
        int n;
        n = int'(shape_count);
        if (n < 1)
            n = 1;
        if (n > DEF_MAX_AXES)
            n = DEF_MAX_AXES;
        return n;
    endfunction

    function automatic logic [DEF_EXTENT_BITS-1:0] extent_eff(input int axis);
        return (shape_extent[axis] == '0) ? DEF_EXTENT_BITS'(1) : shape_extent[axis];
    endfunction

    function automatic void derive_strides();
        logic [63:0] acc;
        logic [63:0] stride_w;
        logic [63:0] ext_w;
        int          n;
        int          i;
        n   = axes_in_use();
        acc = 64'd1;
        for (i = 0; i < IF_AXES; i++)
            shape_stride[i] = STRIDE_BITS'(1);
        // last axis in use has stride 1; walk toward axis 0
        for (i = n - 1; i >= 0; i--)
        begin
            shape_stride[i] = acc[STRIDE_BITS-1:0];
            stride_w        = 64'(shape_stride[i]);
            ext_w           = 64'(extent_eff(i));
            acc             = (stride_w * ext_w) & {16'd0, FLAT_MAX};
        end
        shape_total = acc[FLAT_BITS-1:0];
    endfunction

    function automatic index_res_t convert_request(input index_req_t req);
        index_res_t  res;
        logic [63:0] rest;
        logic [63:0] quo;
        logic [63:0] acc;
        logic [63:0] stride_w;
        logic [63:0] coord_w;
        int          n;
        int          i;
        res = '0;
        n   = axes_in_use();
        if (req.cmd == CMD_TO_COORD)
        begin
            rest = {16'd0, req.flat};
            res.out_of_range = (req.flat >= shape_total);
            for (i = 0; i < n; i++)
            begin
                stride_w = 64'(shape_stride[i]);
                quo      = rest / stride_w;
                rest     = rest % stride_w;
                if (i == 0)
                    res.coord0 = quo[FLAT_BITS-1:0];
                else
                    res.coord_tail[i] = quo[PORT_COORD_BITS-1:0];
            end
        end
        else
        begin
            acc = '0;
            for (i = 0; i < n; i++)
            begin
                if (req.coord[i] >= extent_eff(i))
                    res.out_of_range = 1'b1;
                stride_w = 64'(shape_stride[i]);
                coord_w  = 64'(req.coord[i]);
                acc      = acc + coord_w * stride_w;
            end
            res.flat_result = acc[FLAT_BITS-1:0];
        end
        return res;
    endfunction

    function automatic index_req_t make_request(input logic [CMD_BITS-1:0] cmd,
                                                input logic [FLAT_BITS-1:0] flat,
                                                input logic [PORT_COORD_BITS-1:0] c0,
                                                input logic [PORT_COORD_BITS-1:0] c1,
                                                input logic [PORT_COORD_BITS-1:0] c2,
                                                input logic [PORT_COORD_BITS-1:0] c3);
        index_req_t req;
        req.cmd   = cmd;
        req.flat  = flat;
        req.coord = {c3, c2, c1, c0};
        return req;
    endfunction

    function automatic index_req_t random_request();
        index_req_t  req;
        logic [63:0] pick;
        logic [63:0] total_w;
        int          sel;
        int          i;
        req.cmd  = ($urandom_range(1) != 0) ? CMD_TO_FLAT : CMD_TO_COORD;
        req.flat = FLAT_BITS'({$urandom, $urandom});
        for (i = 0; i < IF_AXES; i++)
            req.coord[i] = PORT_COORD_BITS'($urandom);
        total_w = 64'(shape_total);
        if (req.cmd == CMD_TO_COORD)
        begin
            sel  = int'($urandom_range(9));
            pick = {$urandom, $urandom};
            if (sel < 7)
                req.flat = FLAT_BITS'(pick % total_w);
            else if (sel == 7)
                req.flat = FLAT_BITS'(total_w + 64'($urandom_range(3)));
            else if (sel == 8)
                req.flat = FLAT_BITS'(total_w - 64'd1);
        end
        else
        begin
            // keep most coordinates in bounds, leave some at random
            for (i = 0; i < IF_AXES; i++)
                if ($urandom_range(9) != 0)
                    req.coord[i] = PORT_COORD_BITS'($urandom % extent_eff(i));
        end
        return req;
    endfunction

    function automatic logic [DEF_EXTENT_BITS-1:0] rand_extent();
        return DEF_EXTENT_BITS'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [DEF_EXTENT_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_AXIS_COUNT:
                shape_count = data[AXIS_COUNT_BITS-1:0];
            CFG_EXTENT0, CFG_EXTENT1, CFG_EXTENT2, CFG_EXTENT3:
                shape_extent[2'(idx - CFG_EXTENT0)] = data;
            default:
                ;
        endcase
        if (idx <= CFG_EXTENT3)
            derive_strides();
    endtask

    task automatic program_shape(input logic [AXIS_COUNT_BITS-1:0] count,
                                 input logic [DEF_EXTENT_BITS-1:0] e0,
                                 input logic [DEF_EXTENT_BITS-1:0] e1,
                                 input logic [DEF_EXTENT_BITS-1:0] e2,
                                 input logic [DEF_EXTENT_BITS-1:0] e3);
        logic [DEF_EXTENT_BITS-1:0] count_word;
        count_word = rand_extent();
        count_word[AXIS_COUNT_BITS-1:0] = count;
        write_reg(CFG_AXIS_COUNT, count_word);
        // an index past the register list must leave the shape alone
        write_reg(CFG_INDEX_BITS'(CFG_SPARE_FIRST + CFG_INDEX_BITS'($urandom_range(2))),
                  rand_extent());
        write_reg(CFG_EXTENT0, e0);
        write_reg(CFG_EXTENT1, e1);
        write_reg(CFG_EXTENT2, e2);
        write_reg(CFG_EXTENT3, e3);
    endtask

    // sample after the clock edge has settled so a freshly loaded transfer is seen
    task automatic wait_drained();
        while (pending_req.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_result(input index_res_t got);
        index_res_t want;
        if (expected_res.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display({"ERROR: result with no request outstanding: ",
                          "flat %h c0 %h c1 %h c2 %h c3 %h oor %b"},
                         got.flat_result, got.coord0, got.coord_tail[1], got.coord_tail[2],
                         got.coord_tail[3], got.out_of_range);
        end
        else
        begin
            want = expected_res.pop_front();
            if (got.flat_result !== want.flat_result || got.coord0 !== want.coord0 ||
                got.coord_tail[1] !== want.coord_tail[1] ||
                got.coord_tail[2] !== want.coord_tail[2] ||
                got.coord_tail[3] !== want.coord_tail[3] ||
                got.out_of_range !== want.out_of_range)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("ERROR: expected flat %h c0 %h c1 %h c2 %h c3 %h oor %b",
                             want.flat_result, want.coord0, want.coord_tail[1],
                             want.coord_tail[2], want.coord_tail[3], want.out_of_range);
                    $display("       actual   flat %h c0 %h c1 %h c2 %h c3 %h oor %b",
                             got.flat_result, got.coord0, got.coord_tail[1],
                             got.coord_tail[2], got.coord_tail[3], got.out_of_range);
                end
            end
        end
    endtask

    // request driver: predict on each transfer, then load the next item
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_res.push_back(convert_request(in_flight));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_flight      = pending_req.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {in_flight.coord, in_flight.flat};
                    s_axis_tuser  <= in_flight.cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result({m_axis_tdata[0 +: FLAT_BITS],
                              m_axis_tdata[FLAT_BITS +: FLAT_BITS],
                              m_axis_tdata[2*FLAT_BITS + 2*PORT_COORD_BITS +: PORT_COORD_BITS],
                              m_axis_tdata[2*FLAT_BITS + PORT_COORD_BITS +: PORT_COORD_BITS],
                              m_axis_tdata[2*FLAT_BITS +: PORT_COORD_BITS],
                              m_axis_tdata[2*FLAT_BITS + 3*PORT_COORD_BITS]});
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("nd_flat_index_converter_top verification failed");
            $finish;
        end
    end

    initial
    begin
        int regime;
        int k;
        int i;
        shape_count = AXIS_COUNT_BITS'(1);
        for (i = 0; i < IF_AXES; i++)
            shape_extent[i] = DEF_EXTENT_BITS'(1);
        derive_strides();
        send_idle_pct = 33;
        recv_idle_pct = 57;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset shape: one axis of extent one
        pending_req.push_back(make_request(CMD_TO_COORD, 0, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, 1, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, FLAT_MAX, COORD_MAX, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_FLAT, FLAT_MAX, 0, COORD_MAX, COORD_MAX,
                                           COORD_MAX));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, 1, 0, 0, 0));
        wait_drained();

        // three axes in use; axis 3 extent must be ignored
        program_shape(3, 10, 20, 30, COORD_MAX);
        pending_req.push_back(make_request(CMD_TO_COORD, 0, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, 5999, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, 6000, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, FLAT_MAX, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, 9, 19, 29, COORD_MAX));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, 10, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, 0, 20, 0, 0));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, 0, 0, 30, 0));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                                           COORD_MAX));
        wait_drained();

        // largest array: four axes of maximum extent
        program_shape(4, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        pending_req.push_back(make_request(CMD_TO_COORD, shape_total - FLAT_BITS'(1),
                                           0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, shape_total, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_COORD, FLAT_MAX, 0, 0, 0, 0));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, 4094, 4094, 4094, 4094));
        pending_req.push_back(make_request(CMD_TO_FLAT, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                                           COORD_MAX));

        for (regime = 0; regime < 3; regime++)
        begin
            if (regime == 1)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 33;
            end
            else if (regime == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (k = 0; k < 3; k++)
            begin
                wait_drained();
                case (regime * 3 + k)
                    0: program_shape(4, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
                    1: program_shape(1, COORD_MAX, rand_extent(), rand_extent(),
                                     rand_extent());
                    // zero axes behaves as one
                    2: program_shape(0, rand_extent(), rand_extent(), rand_extent(),
                                     rand_extent());
                    // zero extent behaves as one
                    3: program_shape(2, 0, DEF_EXTENT_BITS'($urandom_range(1, 64)),
                                     rand_extent(), rand_extent());
                    // counts above four saturate
                    4: program_shape(7, DEF_EXTENT_BITS'($urandom_range(1, 16)),
                                     DEF_EXTENT_BITS'($urandom_range(1, 16)),
                                     DEF_EXTENT_BITS'($urandom_range(1, 16)),
                                     DEF_EXTENT_BITS'($urandom_range(1, 16)));
                    5: program_shape(3, DEF_EXTENT_BITS'($urandom_range(1, 4095)),
                                     DEF_EXTENT_BITS'($urandom_range(1, 4095)),
                                     DEF_EXTENT_BITS'($urandom_range(1, 4095)),
                                     rand_extent());
                    6: program_shape(5,
                        DEF_EXTENT_BITS'($urandom_range(1) ? 0 : $urandom_range(4095)),
                        DEF_EXTENT_BITS'($urandom_range(1) ? 0 : $urandom_range(4095)),
                        DEF_EXTENT_BITS'($urandom_range(1) ? 0 : $urandom_range(4095)),
                        DEF_EXTENT_BITS'($urandom_range(1) ? 0 : $urandom_range(4095)));
                    7: program_shape(4, 1, 1, 1, 1);
                    default: program_shape(AXIS_COUNT_BITS'($urandom_range(7)),
                                           rand_extent(), rand_extent(), rand_extent(),
                                           rand_extent());
                endcase
                for (i = 0; i < PHASE_ITEMS; i++)
                    pending_req.push_back(random_request());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("nd_flat_index_converter_top verification clean");
        else
            $display("nd_flat_index_converter_top verification failed");
        $finish;
    end

endmodule

### files.f
rtl/ndfic_pkg.sv
rtl/ndfic_mul.sv
rtl/ndfic_div.sv
rtl/nd_flat_index_converter_top.sv
dv/testbench.sv
